// ===== src/cci_pkg.sv =====
`default_nettype none
package cci_pkg;

   localparam int FRAC_BITS = 8;

   localparam int COORD_W = 16;
   localparam int RAD_W = 15;
   localparam int DELTA_W = COORD_W + 1;
   localparam int MAG_W = COORD_W;
   localparam int SUM_W = RAD_W + 1;
   localparam int SQ_W = 2 * SUM_W;
   localparam int RSQ_W = 2 * RAD_W;
   localparam int D2_W = 2 * DELTA_W;
   localparam int K_W = D2_W;
   localparam int KE_W = K_W + DELTA_W;
   localparam int Q_W = 2 * SQ_W;
   localparam int S_W = Q_W;
   localparam int HALF_W = S_W / 2;
   localparam int PP_W = HALF_W + MAG_W;
   localparam int SQRT_STAGES = S_W;
   localparam int SQRT_REM_W = S_W + 3;
   localparam int M_W = KE_W + HALF_W;
   localparam int NUM_W = M_W + FRAC_BITS + 2;
   localparam int DEN_SHIFT = HALF_W + 2;
   localparam int QB = 41;
   localparam int DIV_STAGES = QB + 1;
   localparam int OUT_W = 25;
   localparam int OUT_MAX = 16777215;
   localparam int OUT_MIN = -16777216;
   localparam int V_W = ((COORD_W + FRAC_BITS > QB) ? COORD_W + FRAC_BITS : QB) + 2;
   localparam int NPT = 4;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [K_W-1:0]     k;
      logic [SQ_W-1:0]           d2;
   } tag_type;

   typedef struct packed {
      tag_type        tag;
      logic [Q_W-1:0] q;
   } job_type;

endpackage
`default_nettype wire

// ===== src/cci_front.sv =====
`default_nettype none
module cci_front import cci_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_first_center_x,
   input  logic signed [COORD_W-1:0] req_first_center_y,
   input  logic signed [COORD_W-1:0] req_second_center_x,
   input  logic signed [COORD_W-1:0] req_second_center_y,
   input  logic [RAD_W-1:0]          req_first_radius,
   input  logic [RAD_W-1:0]          req_second_radius,
   output logic                      push_valid,
   input  logic                      push_ready,
   output job_type                   push_data
);

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [COORD_W-1:0] x1_s1_ff, y1_s1_ff, x1_s2_ff, y1_s2_ff;
   logic signed [DELTA_W-1:0] dx_s1_ff, dy_s1_ff, dx_s2_ff, dy_s2_ff;
   logic signed [DELTA_W-1:0] dx_in, dy_in;
   logic [SUM_W-1:0]          sum_s1_ff;
   logic [RAD_W-1:0]          diff_s1_ff, r1_s1_ff, r2_s1_ff, diff_in;
   logic signed [D2_W-1:0]    dx2_in, dy2_in;
   logic [D2_W-1:0]           dx2_s2_ff, dy2_s2_ff, d2_in;
   logic [SQ_W-1:0]           sumsq_s2_ff;
   logic [RSQ_W-1:0]          diffsq_s2_ff, r1sq_s2_ff, r2sq_s2_ff;
   tag_type                   tag_s3_ff, tag_in;
   logic [SQ_W-1:0]           a1_s3_ff, a2_s3_ff, a1_in, a2_in;
   job_type                   job_s4_ff;

   // hold every stage while the last one cannot hand its beat to the queue
   assign advance = !v4_ff || push_ready;
   assign req_ready = advance;
   assign push_valid = v4_ff;
   assign push_data = job_s4_ff;

   assign dx_in = DELTA_W'(req_second_center_x) - DELTA_W'(req_first_center_x);
   assign dy_in = DELTA_W'(req_second_center_y) - DELTA_W'(req_first_center_y);
   assign diff_in = (req_first_radius > req_second_radius) ?
                    req_first_radius - req_second_radius :
                    req_second_radius - req_first_radius;

   assign dx2_in = dx_s1_ff * dx_s1_ff;
   assign dy2_in = dy_s1_ff * dy_s1_ff;

   always_comb begin
      d2_in = dx2_s2_ff + dy2_s2_ff;
      tag_in.hit = (d2_in <= D2_W'(sumsq_s2_ff)) && (d2_in > D2_W'(diffsq_s2_ff));
      tag_in.x1 = x1_s2_ff;
      tag_in.y1 = y1_s2_ff;
      tag_in.dx = dx_s2_ff;
      tag_in.dy = dy_s2_ff;
      tag_in.k = K_W'(r1sq_s2_ff) - K_W'(r2sq_s2_ff) + K_W'(d2_in);
      tag_in.d2 = d2_in[SQ_W-1:0];
      a1_in = sumsq_s2_ff - d2_in[SQ_W-1:0];
      a2_in = d2_in[SQ_W-1:0] - SQ_W'(diffsq_s2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_s1_ff <= req_first_center_x;
         y1_s1_ff <= req_first_center_y;
         dx_s1_ff <= dx_in;
         dy_s1_ff <= dy_in;
         sum_s1_ff <= SUM_W'(req_first_radius) + SUM_W'(req_second_radius);
         diff_s1_ff <= diff_in;
         r1_s1_ff <= req_first_radius;
         r2_s1_ff <= req_second_radius;

         x1_s2_ff <= x1_s1_ff;
         y1_s2_ff <= y1_s1_ff;
         dx_s2_ff <= dx_s1_ff;
         dy_s2_ff <= dy_s1_ff;
         dx2_s2_ff <= dx2_in;
         dy2_s2_ff <= dy2_in;
         sumsq_s2_ff <= sum_s1_ff * sum_s1_ff;
         diffsq_s2_ff <= diff_s1_ff * diff_s1_ff;
         r1sq_s2_ff <= r1_s1_ff * r1_s1_ff;
         r2sq_s2_ff <= r2_s1_ff * r2_s1_ff;

         tag_s3_ff <= tag_in;
         a1_s3_ff <= a1_in;
         a2_s3_ff <= a2_in;

         job_s4_ff.tag <= tag_s3_ff;
         job_s4_ff.q <= a1_s3_ff * a2_s3_ff;
      end
   end

endmodule
`default_nettype wire

// ===== src/cci_fifo.sv =====
`default_nettype none
module cci_fifo import cci_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ff, rd_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic                    do_push, do_pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = mem_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         unique case ({do_push, do_pop})
            2'b10: count_ff <= count_ff + 1'b1;
            2'b01: count_ff <= count_ff - 1'b1;
            2'b00, 2'b11: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== src/cci_sqrt.sv =====
`default_nettype none
module cci_sqrt import cci_pkg::*; (
   input  logic           clock,
   input  logic           advance,
   input  logic [Q_W-1:0] rad,
   output logic [S_W-1:0] root
);

   // one root bit per stage; the radicand is rad followed by Q_W zero bits
   logic [SQRT_REM_W-1:0] rem_ff [SQRT_STAGES];
   logic [SQRT_REM_W-1:0] rem_in [SQRT_STAGES];
   logic [S_W-1:0]        root_ff [SQRT_STAGES];
   logic [S_W-1:0]        root_in [SQRT_STAGES];
   logic [Q_W-1:0]        rad_ff [SQRT_STAGES];
   logic [Q_W-1:0]        rad_in [SQRT_STAGES];

   assign root = root_ff[SQRT_STAGES-1];

   always_comb begin
      logic [SQRT_REM_W-1:0] rem_prev, rem_shift, trial;
      logic [S_W-1:0]        root_prev;
      logic [Q_W-1:0]        rad_prev;
      logic [1:0]            pair;
      logic                  ge;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            rem_prev = '0;
            root_prev = '0;
            rad_prev = rad;
         end else begin
            rem_prev = rem_ff[j-1];
            root_prev = root_ff[j-1];
            rad_prev = rad_ff[j-1];
         end
         pair = 2'b00;
         if (j < Q_W / 2) pair = rad_prev[Q_W-2-2*j +: 2];
         rem_shift = {rem_prev[SQRT_REM_W-3:0], pair};
         trial = {1'b0, root_prev, 2'b01};
         ge = rem_shift >= trial;
         rem_in[j] = ge ? rem_shift - trial : rem_shift;
         root_in[j] = {root_prev[S_W-2:0], ge};
         rad_in[j] = rad_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         rad_ff <= rad_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/cci_div.sv =====
`default_nettype none
module cci_div import cci_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [SQ_W-1:0]  d2,
   output logic [QB-1:0]    quot
);

   // divisor is d2 << DEN_SHIFT; first stage flags quotients past QB bits
   logic [NUM_W-1:0] rem_ff [DIV_STAGES];
   logic [NUM_W-1:0] rem_in [DIV_STAGES];
   logic [QB-1:0]    quo_ff [DIV_STAGES];
   logic [QB-1:0]    quo_in [DIV_STAGES];
   logic             ovf_ff [DIV_STAGES];
   logic             ovf_in [DIV_STAGES];
   logic [SQ_W-1:0]  d2_ff [DIV_STAGES];
   logic [SQ_W-1:0]  d2_in [DIV_STAGES];
   logic [QB-1:0]    last_q;
   logic             cap;

   always_comb begin
      logic [NUM_W-1:0] rem_prev;
      logic             ge;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            ovf_in[j] = (num >> (DEN_SHIFT + QB)) >= NUM_W'(d2);
            rem_in[j] = num;
            quo_in[j] = '0;
            d2_in[j] = d2;
         end else begin
            rem_prev = rem_ff[j-1];
            ge = (rem_prev >> (DEN_SHIFT + QB - j)) >= NUM_W'(d2_ff[j-1]);
            rem_in[j] = ge ? rem_prev - (NUM_W'(d2_ff[j-1]) << (DEN_SHIFT + QB - j))
                           : rem_prev;
            quo_in[j] = quo_ff[j-1];
            quo_in[j][QB-j] = ge;
            ovf_in[j] = ovf_ff[j-1];
            d2_in[j] = d2_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         ovf_ff <= ovf_in;
         d2_ff <= d2_in;
      end
   end

   // limit the magnitude to 2^(QB-1)
   assign last_q = quo_ff[DIV_STAGES-1];
   assign cap = ovf_ff[DIV_STAGES-1] || (last_q[QB-1] && (|last_q[QB-2:0]));
   assign quot = cap ? {1'b1, {(QB-1){1'b0}}} : last_q;

endmodule
`default_nettype wire

// ===== src/cci_back.sv =====
`default_nettype none
module cci_back import cci_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  job_type                 pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic signed [OUT_W-1:0] rsp_point_one_x,
   output logic signed [OUT_W-1:0] rsp_point_one_y,
   output logic signed [OUT_W-1:0] rsp_point_two_x,
   output logic signed [OUT_W-1:0] rsp_point_two_y
);

   typedef struct packed {
      logic             neg;
      logic [M_W-1:0]   mag;
   } signed_mag_type;

   function automatic signed_mag_type combine(logic [M_W-1:0] a, logic an,
                                              logic [M_W-1:0] b, logic bn);
      signed_mag_type r;
      if (an == bn) begin
         r.mag = a + b;
         r.neg = an;
      end else if (a >= b) begin
         r.mag = a - b;
         r.neg = an;
      end else begin
         r.mag = b - a;
         r.neg = bn;
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] place(logic signed [COORD_W-1:0] base,
                                                     logic [QB-1:0] qm, logic neg);
      logic signed [V_W-1:0] v;
      logic signed [V_W-1:0] off;
      v = V_W'(base) <<< FRAC_BITS;
      off = $signed(V_W'(qm));
      v = neg ? v - off : v + off;
      if (v > OUT_MAX) return OUT_W'(OUT_MAX);
      else if (v < OUT_MIN) return OUT_W'(OUT_MIN);
      else return OUT_W'(v);
   endfunction

   logic advance;
   logic rsp_valid_ff, rsp_hit_ff;
   logic signed [OUT_W-1:0] rsp_pt_ff [NPT];

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   // square root, tag rides alongside
   logic [S_W-1:0] root;
   logic    sv_ff [SQRT_STAGES];
   tag_type stag_ff [SQRT_STAGES];

   cci_sqrt u_sqrt (
      .clock   (clock),
      .advance (advance),
      .rad     (pop_data.q),
      .root    (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '{default: 1'b0};
      end else if (advance) begin
         sv_ff[0] <= pop_valid;
         for (int j = 1; j < SQRT_STAGES; j++) sv_ff[j] <= sv_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stag_ff[0] <= pop_data.tag;
         for (int j = 1; j < SQRT_STAGES; j++) stag_ff[j] <= stag_ff[j-1];
      end
   end

   // first product stage: K times delta, root times |delta| in halves
   tag_type                 stail, m1_tag_ff, m2_tag_ff, m3_tag_ff, m4_tag_ff;
   logic signed [K_W-1:0]   k_s;
   logic signed [DELTA_W-1:0] dx_s, dy_s;
   logic [MAG_W-1:0]        adx, ady;
   logic signed [KE_W-1:0]  kdx_in, kdy_in, kdx_ff, kdy_ff;
   logic [PP_W-1:0]         ppx_lo_ff, ppx_hi_ff, ppy_lo_ff, ppy_hi_ff;
   logic                    m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff;

   assign stail = stag_ff[SQRT_STAGES-1];
   assign k_s = stail.k;
   assign dx_s = stail.dx;
   assign dy_s = stail.dy;
   assign adx = MAG_W'((dx_s < 0) ? -dx_s : dx_s);
   assign ady = MAG_W'((dy_s < 0) ? -dy_s : dy_s);
   assign kdx_in = k_s * dx_s;
   assign kdy_in = k_s * dy_s;

   // second stage: align K terms, sum root partial products
   logic [KE_W-1:0] kx_mag, ky_mag;
   logic [M_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic            kx_neg_ff, ky_neg_ff;

   assign kx_mag = (kdx_ff < 0) ? KE_W'(-kdx_ff) : KE_W'(kdx_ff);
   assign ky_mag = (kdy_ff < 0) ? KE_W'(-kdy_ff) : KE_W'(kdy_ff);

   // third stage: signed combine for the four coordinates
   // order: point one x, point one y, point two x, point two y
   signed_mag_type comb_in [NPT];
   signed_mag_type comb_ff [NPT];
   logic signed [DELTA_W-1:0] dx_m2, dy_m2;

   assign dx_m2 = m2_tag_ff.dx;
   assign dy_m2 = m2_tag_ff.dy;

   always_comb begin
      comb_in[0] = combine(ax_ff, kx_neg_ff, by_ff, dy_m2 > 0);
      comb_in[1] = combine(ay_ff, ky_neg_ff, bx_ff, dx_m2 < 0);
      comb_in[2] = combine(ax_ff, kx_neg_ff, by_ff, dy_m2 < 0);
      comb_in[3] = combine(ay_ff, ky_neg_ff, bx_ff, dx_m2 > 0);
   end

   // fourth stage: rounding numerator (2m << F) + divisor/2
   logic [NUM_W-1:0] num_ff [NPT];
   logic [NPT-1:0]   neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
      end else if (advance) begin
         m1_v_ff <= sv_ff[SQRT_STAGES-1];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         m4_v_ff <= m3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_tag_ff <= stail;
         kdx_ff <= kdx_in;
         kdy_ff <= kdy_in;
         ppx_lo_ff <= root[HALF_W-1:0] * adx;
         ppx_hi_ff <= root[S_W-1:HALF_W] * adx;
         ppy_lo_ff <= root[HALF_W-1:0] * ady;
         ppy_hi_ff <= root[S_W-1:HALF_W] * ady;

         m2_tag_ff <= m1_tag_ff;
         ax_ff <= {kx_mag, {HALF_W{1'b0}}};
         ay_ff <= {ky_mag, {HALF_W{1'b0}}};
         kx_neg_ff <= kdx_ff < 0;
         ky_neg_ff <= kdy_ff < 0;
         bx_ff <= (M_W'(ppx_hi_ff) << HALF_W) + M_W'(ppx_lo_ff);
         by_ff <= (M_W'(ppy_hi_ff) << HALF_W) + M_W'(ppy_lo_ff);

         m3_tag_ff <= m2_tag_ff;
         comb_ff <= comb_in;

         m4_tag_ff <= m3_tag_ff;
         for (int p = 0; p < NPT; p++) begin
            num_ff[p] <= (NUM_W'(comb_ff[p].mag) << (FRAC_BITS + 1)) +
                         (NUM_W'(m3_tag_ff.d2) << (DEN_SHIFT - 1));
            neg_ff[p] <= comb_ff[p].neg;
         end
      end
   end

   // dividers, tag and signs delayed to match
   logic [QB-1:0]  qm [NPT];
   logic           dv_ff [DIV_STAGES];
   tag_type        dtag_ff [DIV_STAGES];
   logic [NPT-1:0] dneg_ff [DIV_STAGES];

   for (genvar p = 0; p < NPT; p++) begin : g_div
      cci_div u_div (
         .clock   (clock),
         .advance (advance),
         .num     (num_ff[p]),
         .d2      (m4_tag_ff.d2),
         .quot    (qm[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '{default: 1'b0};
      end else if (advance) begin
         dv_ff[0] <= m4_v_ff;
         for (int j = 1; j < DIV_STAGES; j++) dv_ff[j] <= dv_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dtag_ff[0] <= m4_tag_ff;
         dneg_ff[0] <= neg_ff;
         for (int j = 1; j < DIV_STAGES; j++) begin
            dtag_ff[j] <= dtag_ff[j-1];
            dneg_ff[j] <= dneg_ff[j-1];
         end
      end
   end

   // output register: place offsets on circle one, saturate, zero on miss
   tag_type        dtail;
   logic [NPT-1:0] dneg_tail;

   assign dtail = dtag_ff[DIV_STAGES-1];
   assign dneg_tail = dneg_ff[DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= dtail.hit;
         for (int p = 0; p < NPT; p++) begin
            if (dtail.hit)
               rsp_pt_ff[p] <= place((p % 2 == 0) ? dtail.x1 : dtail.y1, qm[p],
                                     dneg_tail[p]);
            else
               rsp_pt_ff[p] <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_point_one_x = rsp_pt_ff[0];
   assign rsp_point_one_y = rsp_pt_ff[1];
   assign rsp_point_two_x = rsp_pt_ff[2];
   assign rsp_point_two_y = rsp_pt_ff[3];

endmodule
`default_nettype wire

// ===== src/circle_circle_intersection.sv =====
`default_nettype none
// Channel   Direction  Beat contents
// req_      in         two circle centers (16b signed) and two radii (15b)
// rsp_      out        hit flag and two crossing points (25b, FRAC_BITS fraction)
//
// One beat per cycle is accepted and one result per cycle delivered while
// rsp_ready stays high. A beat passes through the front stages, the queue,
// 64 square-root stages, 4 product/combine stages, 42 divider stages and
// the output register. Reset is synchronous and clears all valid bits and
// the queue. A stall on rsp_ is absorbed by the 4-entry queue before req_ready
// drops.
module circle_circle_intersection import cci_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_first_center_x,
   input  logic signed [COORD_W-1:0] req_first_center_y,
   input  logic signed [COORD_W-1:0] req_second_center_x,
   input  logic signed [COORD_W-1:0] req_second_center_y,
   input  logic [RAD_W-1:0]          req_first_radius,
   input  logic [RAD_W-1:0]          req_second_radius,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic signed [OUT_W-1:0]   rsp_point_one_x,
   output logic signed [OUT_W-1:0]   rsp_point_one_y,
   output logic signed [OUT_W-1:0]   rsp_point_two_x,
   output logic signed [OUT_W-1:0]   rsp_point_two_y
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   // front: differences, squares, hit test, K and the root radicand
   cci_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_first_center_x  (req_first_center_x),
      .req_first_center_y  (req_first_center_y),
      .req_second_center_x (req_second_center_x),
      .req_second_center_y (req_second_center_y),
      .req_first_radius    (req_first_radius),
      .req_second_radius   (req_second_radius),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   // queue lets front and back stall independently
   cci_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: square root, products, rounding divide, saturate
   cci_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_point_one_x (rsp_point_one_x),
      .rsp_point_one_y (rsp_point_one_y),
      .rsp_point_two_x (rsp_point_two_x),
      .rsp_point_two_y (rsp_point_two_y)
   );

endmodule
`default_nettype wire
